[rtl/wsfu_pkg.sv]
package wsfu_pkg;

  localparam int unsigned MAX_PAYLOAD = 125;

  localparam logic [3:0] FIN_ONLY      = 4'h8;
  localparam logic [3:0] OPCODE_BINARY = 4'h2;

  // result status codes
  localparam logic [1:0] ST_DATA       = 2'd0;
  localparam logic [1:0] ST_EMPTY      = 2'd1;
  localparam logic [1:0] ST_BAD_HDR    = 2'd2;
  localparam logic [1:0] ST_BAD_OPCODE = 2'd3;

  typedef enum logic [4:0] {
    PH_HDR0 = 5'b00001,
    PH_HDR1 = 5'b00010,
    PH_MASK = 5'b00100,
    PH_DATA = 5'b01000,
    PH_HALT = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic [1:0] status;
    logic       last;
  } result_t;

endpackage

[rtl/wsfu_in_if.sv]
interface wsfu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

[rtl/wsfu_out_if.sv]
interface wsfu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic [1:0] status;
  logic       last;

  modport source (output valid, output payload_byte, output status, output last, input ready);
  modport sink   (input valid, input payload_byte, input status, input last, output ready);
endinterface

[rtl/websocket_frame_unmasker_unit.sv]
// WebSocket receive deframer for short frames (7-bit length, masked, binary).
// in_ch: one received byte per item (rx_byte), valid/ready handshake.
// out_ch: result items {payload_byte, status, last}, valid/ready handshake.
// Header and mask-key bytes give no result; each payload byte gives one
// unmasked data item, last set on the final byte. A zero-length frame gives
// one empty-frame item on its fourth mask byte. A bad header gives one error
// item on header byte 1; the block then drops all input until reset.
// Throughput: one byte per clock, sustained, while out_ch keeps taking items.
// Path: an accepted byte is registered in the input register, processed
// against the frame state combinationally, and its result is loaded into
// the output register when the byte moves on; out_ch.valid comes from it.
// Stall: when out_ch stalls, the held result waits in the output register;
// one more byte is held in the input register, and in_ch.ready drops only
// when a result-producing byte cannot move on. Bytes that give no result
// pass through the frame state even while out_ch is stalled.
// Reset (rst_n low, synchronous): both registers empty, frame state back to
// waiting for header byte 0, mask key and counters cleared.
module websocket_frame_unmasker_unit (
  input  logic       clk,
  input  logic       rst_n,
  wsfu_in_if.sink    in_ch,
  wsfu_out_if.source out_ch
);

  logic              hold_valid;
  logic [7:0]        hold_byte;
  logic              consume;
  logic              res_valid;
  logic              room;
  wsfu_pkg::result_t res;
  wsfu_pkg::result_t out_res;

  // a held byte moves on unless it makes a result that has nowhere to go
  assign consume = hold_valid && (!res_valid || room);

  wsfu_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_byte   (in_ch.rx_byte),
    .in_ready  (in_ch.ready),
    .consume   (consume),
    .hold_valid(hold_valid),
    .hold_byte (hold_byte)
  );

  wsfu_deframer u_deframer (
    .clk      (clk),
    .rst_n    (rst_n),
    .rx_byte  (hold_byte),
    .consume  (consume),
    .res_valid(res_valid),
    .res      (res)
  );

  wsfu_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (consume && res_valid),
    .load_res (res),
    .room     (room),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_res  (out_res)
  );

  assign out_ch.payload_byte = out_res.payload_byte;
  assign out_ch.status       = out_res.status;
  assign out_ch.last         = out_res.last;

endmodule

[rtl/wsfu_in_stage.sv]
module wsfu_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  output logic       in_ready,
  input  logic       consume,
  output logic       hold_valid,
  output logic [7:0] hold_byte
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;

  assign in_ready = !valid_r || consume;

  always_comb begin
    valid_nxt = valid_r;
    if (consume) valid_nxt = 1'b0;
    if (in_valid && in_ready) valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) byte_r <= in_byte;
  end

  assign hold_valid = valid_r;
  assign hold_byte  = byte_r;

endmodule

[rtl/wsfu_deframer.sv]
module wsfu_deframer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        rx_byte,
  input  logic              consume,
  output logic              res_valid,
  output wsfu_pkg::result_t res
);

  wsfu_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]       hdr0_r, hdr0_nxt;
  logic [6:0]       left_r, left_nxt;
  logic [31:0]      key_r, key_nxt;
  logic [1:0]       pos_r, pos_nxt;
  logic [7:0]       key_byte;
  logic [7:0]       shifted_byte;

  always_comb begin
    case (pos_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  always_comb begin
    case (pos_r)
      2'd0:    shifted_byte = 8'h00;
      default: shifted_byte = 8'h00;
    endcase
  end

  always_comb begin
    phase_nxt        = phase_r;
    hdr0_nxt         = hdr0_r;
    left_nxt         = left_r;
    key_nxt          = key_r;
    pos_nxt          = pos_r;
    res_valid        = 1'b0;
    res.payload_byte = shifted_byte;
    res.status       = wsfu_pkg::ST_DATA;
    res.last         = 1'b1;
    case (phase_r)
      wsfu_pkg::PH_HDR0: begin
        hdr0_nxt  = rx_byte;
        phase_nxt = wsfu_pkg::PH_HDR1;
      end
      wsfu_pkg::PH_HDR1: begin
        if (hdr0_r[7:4] != wsfu_pkg::FIN_ONLY || !rx_byte[7]
            || rx_byte[6:0] > 7'(wsfu_pkg::MAX_PAYLOAD)) begin
          phase_nxt  = wsfu_pkg::PH_HALT;
          res_valid  = 1'b1;
          res.status = wsfu_pkg::ST_BAD_HDR;
        end else if (hdr0_r[3:0] != wsfu_pkg::OPCODE_BINARY) begin
          phase_nxt  = wsfu_pkg::PH_HALT;
          res_valid  = 1'b1;
          res.status = wsfu_pkg::ST_BAD_OPCODE;
        end else begin
          left_nxt  = rx_byte[6:0];
          key_nxt   = '0;
          pos_nxt   = 2'd0;
          phase_nxt = wsfu_pkg::PH_MASK;
        end
      end
      wsfu_pkg::PH_MASK: begin
        case (pos_r)
          2'd0:    key_nxt[31:24] = rx_byte;
          2'd1:    key_nxt[23:16] = rx_byte;
          2'd2:    key_nxt[15:8]  = rx_byte;
          default: key_nxt[7:0]   = rx_byte;
        endcase
        pos_nxt = pos_r + 2'd1;
        if (pos_r == 2'd3) begin
          if (left_r == 7'd0) begin
            // empty frame
            phase_nxt  = wsfu_pkg::PH_HDR0;
            res_valid  = 1'b1;
            res.status = wsfu_pkg::ST_EMPTY;
          end else begin
            phase_nxt = wsfu_pkg::PH_DATA;
          end
        end
      end
      wsfu_pkg::PH_DATA: begin
        pos_nxt          = pos_r + 2'd1;
        left_nxt         = left_r - 7'd1;
        res_valid        = 1'b1;
        res.payload_byte = rx_byte ^ key_byte;
        res.last         = (left_r == 7'd1);
        if (left_r == 7'd1) phase_nxt = wsfu_pkg::PH_HDR0;
      end
      default: begin
        // halted: drop every byte until reset
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= wsfu_pkg::PH_HDR0;
      hdr0_r  <= '0;
      left_r  <= '0;
      key_r   <= '0;
      pos_r   <= '0;
    end else if (consume) begin
      phase_r <= phase_nxt;
      hdr0_r  <= hdr0_nxt;
      left_r  <= left_nxt;
      key_r   <= key_nxt;
      pos_r   <= pos_nxt;
    end
  end

endmodule

[rtl/wsfu_out_stage.sv]
module wsfu_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  wsfu_pkg::result_t load_res,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output wsfu_pkg::result_t out_res
);

  logic              valid_r, valid_nxt;
  wsfu_pkg::result_t res_r;

  assign room = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (out_ready) valid_nxt = 1'b0;
    if (load) valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) res_r <= load_res;
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps

// Checks the short-frame WebSocket deframer at one item per clock between random gaps and stalls.
// Traffic is mostly good binary frames with random mask keys and payloads;
// the run closes on a single broken header, since the block halts on it
// for good, followed by bytes it has to swallow silently.
module tb_top;

  localparam int QUIET_LIMIT = 2000;   // cycles with no handshake at all
  localparam int RANDOM_ITEMS = 1850;  // stop starting new frames here
  localparam int CALM_FROM = 1700;     // no idling from here to the end
  localparam int DRAIN_AT = 900;       // one full drain around here

  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;
  typedef enum int {ERR_NO_FIN, ERR_RSV, ERR_NO_MASK, ERR_LONG, ERR_OPCODE} hdr_fault_t;

  // Tracks the frame state on its own and queues the results each received
  // byte must produce; results coming out of the block are popped in order.
  class deframe_scoreboard;
    wsfu_pkg::phase_t  phase;
    logic [7:0]        hdr0;
    logic [6:0]        left;
    logic [31:0]       key;
    logic [1:0]        key_pos;
    wsfu_pkg::result_t due[$];
    int                mismatches;

    function new();
      phase      = wsfu_pkg::PH_HDR0;
      hdr0       = '0;
      left       = '0;
      key        = '0;
      key_pos    = '0;
      mismatches = 0;
    endfunction

    function int pending();
      return due.size();
    endfunction

    function void queue_result(logic [7:0] data, logic [1:0] st, logic lst);
      wsfu_pkg::result_t r;
      r.payload_byte = data;
      r.status       = st;
      r.last         = lst;
      due.push_back(r);
    endfunction

    function void note_rx_byte(logic [7:0] b);
      logic [7:0] key_byte;
      case (phase)
        wsfu_pkg::PH_HDR0: begin
          hdr0  = b;
          phase = wsfu_pkg::PH_HDR1;
        end
        wsfu_pkg::PH_HDR1: begin
          if (hdr0[7:4] != wsfu_pkg::FIN_ONLY || b[6:0] > wsfu_pkg::MAX_PAYLOAD || !b[7]) begin
            queue_result(8'h00, wsfu_pkg::ST_BAD_HDR, 1'b1);
            phase = wsfu_pkg::PH_HALT;
          end else if (hdr0[3:0] != wsfu_pkg::OPCODE_BINARY) begin
            queue_result(8'h00, wsfu_pkg::ST_BAD_OPCODE, 1'b1);
            phase = wsfu_pkg::PH_HALT;
          end else begin
            left    = b[6:0];
            key     = '0;
            key_pos = '0;
            phase   = wsfu_pkg::PH_MASK;
          end
        end
        wsfu_pkg::PH_MASK: begin
          // first key byte lands in the top byte
          key[8 * (3 - int'(key_pos)) +: 8] = b;
          if (key_pos != 2'd3) begin
            key_pos++;
          end else begin
            key_pos = '0;
            if (left == 7'd0) begin
              queue_result(8'h00, wsfu_pkg::ST_EMPTY, 1'b1);
              phase = wsfu_pkg::PH_HDR0;
            end else begin
              phase = wsfu_pkg::PH_DATA;
            end
          end
        end
        wsfu_pkg::PH_DATA: begin
          key_byte = key[8 * (3 - int'(key_pos)) +: 8];
          key_pos++;
          left--;
          queue_result(b ^ key_byte, wsfu_pkg::ST_DATA, left == 7'd0);
          if (left == 7'd0) phase = wsfu_pkg::PH_HDR0;
        end
        default: ;  // halted: byte dropped
      endcase
    endfunction

    task report_mismatch(string what);
      mismatches++;
      // keep the log short if the block is badly off
      if (mismatches <= 100) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_result(logic [7:0] pb, logic [1:0] st, logic lst);
      wsfu_pkg::result_t want;
      if (due.size() == 0) begin
        report_mismatch($sformatf("result %h/%0d/%0b with none due", pb, st, lst));
        return;
      end
      want = due.pop_front();
      if (pb !== want.payload_byte)
        report_mismatch($sformatf("payload_byte %h, want %h", pb, want.payload_byte));
      if (st !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", st, want.status));
      if (lst !== want.last)
        report_mismatch($sformatf("last %0b, want %0b", lst, want.last));
    endtask

    task close_out();
      if (due.size() != 0)
        report_mismatch($sformatf("%0d results never came", due.size()));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;

  wsfu_in_if  in_ch();
  wsfu_out_if out_ch();

  websocket_frame_unmasker_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  deframe_scoreboard sb;

  int items_sent = 0;
  bit idle_on = 1'b1;  // random gaps/stalls allowed
  bit calm = 1'b0;     // per-frame quiet stretch, no gaps even when idle_on
  int stall_left = 0;
  int quiet_cycles = 0;

  always #6 clk = ~clk;

  // Receiver side: ready drops at random, in bursts of random length.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (idle_on && !calm && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 13);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Handshakes are taken at the rising edge; inputs only move on the falling one.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.note_rx_byte(in_ch.rx_byte);
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.payload_byte, out_ch.status, out_ch.last);
    end
  end

  // Watchdog: a correct block never goes this long without some handshake.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Called on a falling edge; returns on the falling edge after the item went in.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (idle_on && !calm && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 14);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(input logic [31:0] mkey, input int len, input fill_t fill);
    logic [7:0] pb;
    send_byte({wsfu_pkg::FIN_ONLY, wsfu_pkg::OPCODE_BINARY});
    send_byte({1'b1, 7'(len)});
    for (int i = 0; i < 4; i++) send_byte(mkey[31 - 8 * i -: 8]);
    for (int i = 0; i < len; i++) begin
      case (fill)
        FILL_ZERO: pb = 8'h00;
        FILL_ONES: pb = 8'hff;
        default:   pb = 8'($urandom);
      endcase
      send_byte(pb);
    end
  endtask

  // Closing frame: one header fault, picked at random. The block halts after it.
  task automatic send_broken_header();
    hdr_fault_t fault;
    logic [7:0] h0, h1;
    fault = hdr_fault_t'($urandom_range(0, 4));
    h0 = {wsfu_pkg::FIN_ONLY, wsfu_pkg::OPCODE_BINARY};
    h1 = {1'b1, 7'($urandom_range(0, wsfu_pkg::MAX_PAYLOAD))};
    case (fault)
      ERR_NO_FIN:  h0 = {1'b0, 3'($urandom), 4'($urandom)};
      ERR_RSV:     h0[6:4] = 3'($urandom_range(1, 7));
      ERR_NO_MASK: h1[7] = 1'b0;
      ERR_LONG:    h1[6:0] = 7'($urandom_range(wsfu_pkg::MAX_PAYLOAD + 1, 127));
      default: begin
        // any opcode but binary; header fields stay clean
        do h0[3:0] = 4'($urandom); while (h0[3:0] == wsfu_pkg::OPCODE_BINARY);
      end
    endcase
    send_byte(h0);
    send_byte(h1);
  endtask

  // Sender holds off until every pending result has been taken.
  task automatic drain_output();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  initial begin
    int len;
    bit drained;
    sb = new();
    drained = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.rx_byte = 8'h00;
    out_ch.ready = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty frame, single byte, and a payload that wraps the key.
    send_frame(32'hffff_ffff, 0, FILL_RANDOM);
    send_frame(32'h0000_0000, 1, FILL_ONES);
    send_frame(32'ha5c3_0f81, 5, FILL_ZERO);

    // Random good frames; mostly short, some long, a few at the maximum.
    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent >= CALM_FROM) idle_on = 1'b0;
      calm = ($urandom_range(0, 3) == 0);
      if (!drained && items_sent >= DRAIN_AT) begin
        drain_output();
        drained = 1'b1;
      end
      case ($urandom_range(0, 23))
        0:       len = wsfu_pkg::MAX_PAYLOAD;
        1, 2, 3: len = $urandom_range(13, wsfu_pkg::MAX_PAYLOAD - 1);
        default: len = $urandom_range(0, 12);
      endcase
      send_frame($urandom, len, FILL_RANDOM);
    end

    // Error result, then input that must be dropped without results.
    idle_on = 1'b0;
    send_broken_header();
    repeat (16) send_byte(8'($urandom));

    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);  // room for a stray late result
    sb.close_out();

    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
